FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_CLK_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg
// Types and codes for the sorted priority queue.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 8;
  localparam int COUNT_W = 7;

  localparam logic       CMD_ENQ      = 1'b0;
  localparam logic       CMD_DEQ      = 1'b1;
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] item_value;
    logic        [PRIO_W-1:0]  item_priority;
  } spq_in_t;

  typedef struct packed {
    logic        [1:0]         status;
    logic signed [VALUE_W-1:0] taken_value;
    logic        [PRIO_W-1:0]  taken_priority;
    logic signed [VALUE_W-1:0] head_value;
    logic        [PRIO_W-1:0]  head_priority;
    logic        [COUNT_W-1:0] entry_count;
  } spq_out_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } spq_entry_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE
  } spq_op_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    spq_op_t    op;
    spq_entry_t new_ent;
  } spq_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: hold, take the new entry, or shift.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell import spq_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire logic             clk,
  input  wire spq_ctrl_t        ctrl,
  input  wire logic [CNT_W-1:0] count,
  input  wire spq_entry_t       left_ent,
  input  wire spq_entry_t       right_ent,
  input  wire logic             left_lt,
  output spq_entry_t            ent,
  output logic                  lt
);

  spq_entry_t ent_r, ent_nxt;
  logic       occ;

  assign occ = CNT_W'(IDX) < count;
  // Occupied and served strictly before the new entry.
  assign lt  = occ && (ent_r.prio < ctrl.new_ent.prio);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (!lt) begin
          ent_nxt = left_lt ? ctrl.new_ent : left_ent;
        end
      end
      OP_REMOVE: ent_nxt = right_ent;
      default:   ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue.sv
// A result beat is registered and appears in the cycle after its command beat is accepted.
// Throughput: one command per cycle while results are taken; every cell moves
//   at most one place per command, so the whole chain shifts in the same cycle.
// Reset clears the entry count and the result valid; cell contents are left
//   as they are and are only read below the count.
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Sorted-array priority queue built as a row of shifting cells.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire spq_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output spq_out_t     out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Chain wiring: entry and "served before new" flag of every cell.
  spq_entry_t             ent   [DEPTH];
  logic       [DEPTH-1:0] lt;

  spq_ctrl_t              ctrl;
  logic                   in_fire;
  logic                   full, empty;
  logic       [CNT_W-1:0] count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  spq_out_t               out_data_r, out_data_nxt;
  spq_entry_t             head_nxt;
  logic       [CNT_W+COUNT_W-1:0] count_ext;

  // Accept a command beat whenever the result register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;

  // Decide what the chain does this cycle; overflow and underflow hold it.
  always_comb begin
    ctrl.new_ent.value = in_data.item_value;
    ctrl.new_ent.prio  = in_data.item_priority;
    ctrl.op            = OP_HOLD;
    if (in_fire) begin
      if (in_data.cmd == CMD_ENQ) begin
        ctrl.op = full ? OP_HOLD : OP_INSERT;
      end else begin
        ctrl.op = empty ? OP_HOLD : OP_REMOVE;
      end
    end
  end

  // The cell row. The first cell sees the new entry as its left neighbour and
  // always inserts when it is not ahead of it; the last cell refills itself.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_entry_t left_ent, right_ent;
    logic       left_lt;

    if (i == 0) begin : g_first
      assign left_ent = ctrl.new_ent;
      assign left_lt  = 1'b1;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign left_lt  = lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    spq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .left_lt   (left_lt),
      .ent       (ent[i]),
      .lt        (lt[i])
    );
  end

  // Count after this command and the head the chain will hold next cycle.
  always_comb begin
    count_nxt = count_r;
    head_nxt  = ent[0];
    case (ctrl.op)
      OP_INSERT: begin
        count_nxt = count_r + CNT_W'(1);
        head_nxt  = lt[0] ? ent[0] : ctrl.new_ent;
      end
      OP_REMOVE: begin
        count_nxt = count_r - CNT_W'(1);
        head_nxt  = ent[1];
      end
      default: begin
        count_nxt = count_r;
        head_nxt  = ent[0];
      end
    endcase
  end

  // The reported count keeps only its low bits when the queue is deep.
  assign count_ext = {{COUNT_W{1'b0}}, count_nxt};

  // Build the result beat.
  always_comb begin
    out_data_nxt.status         = ST_OK;
    out_data_nxt.taken_value    = '0;
    out_data_nxt.taken_priority = '0;
    out_data_nxt.head_value     = '0;
    out_data_nxt.head_priority  = '0;
    out_data_nxt.entry_count    = count_ext[COUNT_W-1:0];
    if (in_data.cmd == CMD_ENQ) begin
      if (full) begin
        out_data_nxt.status = ST_OVERFLOW;
      end
    end else begin
      if (empty) begin
        out_data_nxt.status = ST_UNDERFLOW;
      end else begin
        out_data_nxt.taken_value    = ent[0].value;
        out_data_nxt.taken_priority = ent[0].prio;
      end
    end
    if (count_nxt != '0) begin
      out_data_nxt.head_value    = head_nxt.value;
      out_data_nxt.head_priority = head_nxt.prio;
    end
  end

  // Result valid: set on a command beat, drop once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload register: load only on a command beat, otherwise hold.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spq_checker import spq_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire spq_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire spq_out_t out_data
);

  `ASSERT_CLK_NR(a_reset_drops_valid, clk, !rst_n |=> !out_valid, "result valid after reset")
  `ASSERT_CLK(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result beat changed")
  `ASSERT_CLK(a_underflow_empty, clk, rst_n, out_valid && out_data.status == ST_UNDERFLOW |-> out_data.entry_count == '0 && out_data.taken_value == '0 && out_data.taken_priority == '0, "underflow with entries or taken data")
  `ASSERT_CLK(a_empty_head_zero, clk, rst_n, out_valid && out_data.entry_count == '0 && out_data.status == ST_OK |-> out_data.head_value == '0 && out_data.head_priority == '0, "empty queue reports a head")
  `ASSERT_CLK(a_beat_follows_cmd, clk, rst_n, in_valid && in_ready |=> out_valid, "command beat gave no result")

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire

FILE: tb/sorted_priority_queue_tb.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_tb
// Streams enqueue and dequeue beats into the sorted priority queue, keeps a
// sorted mirror of its store and checks every result beat field by field.
// A short scripted opening covers the reset state, the field extremes, ties
// and the underflow code. Random fill, drain and churn phases follow, with
// random idling on both channels and a calm stretch at the end.
// ---------------------------------------------------------------------------
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH          = 64;
  localparam int RANDOM_BEATS   = 1600;
  localparam int CALM_TAIL      = 300;   // last random beats run with no idling
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on either side
  localparam int SETTLE_CYCLES  = 8;
  localparam int SCRIPT_LEN     = 20;

  typedef enum int {PH_FILL, PH_DRAIN, PH_CHURN} phase_kind_t;
  typedef enum int {PRIO_ANY, PRIO_TIES, PRIO_ENDS, PRIO_BAND} prio_style_t;

  // One scripted command. Where pinned is set, the result is typed in here
  // and replaces the mirror's own answer for that beat.
  typedef struct {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
    bit                        pinned;
    logic        [1:0]         status;
    logic signed [VALUE_W-1:0] head_value;
    logic        [PRIO_W-1:0]  head_prio;
    int                        count;
  } script_row_t;

  logic     clk        = 1'b0;
  logic     rst_n      = 1'b0;
  logic     in_valid   = 1'b0;
  logic     in_ready;
  spq_in_t  in_data    = '0;
  logic     out_valid;
  logic     out_ready  = 1'b0;
  spq_out_t out_data;

  // Typed-in result travelling alongside the command beat it belongs to.
  logic     pin_valid  = 1'b0;
  spq_out_t pin_report = '0;

  // Sink idling: chance of 1 in sink_rate per cycle to start a stall burst.
  int       sink_rate  = 4;
  int       sink_hold  = 0;

  spq_entry_t sorted_store[$];     // mirror of the queue, head at index 0
  spq_out_t   pending_reports[$];  // results owed by the block, oldest first

  int beats_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int n_enq        = 0;
  int n_deq        = 0;
  int n_overflow   = 0;
  int n_underflow  = 0;
  int peak_fill    = 0;

  // Opening sequence: underflow from reset, extremes of value and priority,
  // ties at both ends and in the middle, a full drain down to empty (head
  // reads zero), a second underflow and a pair of alternating bit patterns.
  // Some dequeue payloads carry junk on purpose: the block must ignore them.
  script_row_t script [SCRIPT_LEN] = '{
    '{CMD_DEQ, 32'sd0,         8'd0,   1'b1, ST_UNDERFLOW, 32'sd0,         8'd0,   0},
    '{CMD_ENQ, 32'sh7FFF_FFFF, 8'd255, 1'b1, ST_OK,        32'sh7FFF_FFFF, 8'd255, 1},
    '{CMD_ENQ, 32'sh8000_0000, 8'd0,   1'b1, ST_OK,        32'sh8000_0000, 8'd0,   2},
    '{CMD_ENQ, 32'sd5,         8'd0,   1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_ENQ, -32'sd1,        8'd128, 1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_ENQ, 32'sd0,         8'd128, 1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_ENQ, 32'sd1,         8'd255, 1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_ENQ, 32'sd123,       8'd254, 1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'sh5A5A_5A5A, 8'hA5, 1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, -32'sd1,        8'hFF, 1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'sd0,         8'd0,   1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'sh7FFF_FFFF, 8'd1,   1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'sh8000_0000, 8'd254, 1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'sd77,        8'd12,  1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'sd9,         8'd9,   1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'shDEAD_0001, 8'd3,   1'b1, ST_UNDERFLOW, 32'sd0,         8'd0,   0},
    '{CMD_ENQ, 32'shAAAA_AAAA, 8'h55,  1'b1, ST_OK,        32'shAAAA_AAAA, 8'h55,  1},
    '{CMD_ENQ, 32'sh5555_5555, 8'hAA,  1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'sd0,         8'd0,   1'b0, ST_OK,        32'sd0,         8'd0,   0},
    '{CMD_DEQ, 32'sd0,         8'd0,   1'b0, ST_OK,        32'sd0,         8'd0,   0}
  };

  always #1 clk = ~clk;

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // -------------------------------------------------------------------------
  // Mirror of the sorted store: apply one command and return its result.
  // -------------------------------------------------------------------------
  function automatic spq_out_t apply_command(spq_in_t beat);
    spq_out_t   r;
    spq_entry_t fresh;
    int         pos;
    r = '0;
    if (beat.cmd == CMD_ENQ) begin
      n_enq++;
      if (sorted_store.size() >= DEPTH) begin
        r.status = ST_OVERFLOW;
        n_overflow++;
      end else begin
        // Walk back past every entry whose priority is equal or larger, so
        // the newcomer lands ahead of its equals.
        pos = sorted_store.size();
        while (pos > 0 && sorted_store[pos-1].prio >= beat.item_priority) pos--;
        fresh.value = beat.item_value;
        fresh.prio  = beat.item_priority;
        sorted_store.insert(pos, fresh);
      end
    end else begin
      n_deq++;
      if (sorted_store.size() == 0) begin
        r.status = ST_UNDERFLOW;
        n_underflow++;
      end else begin
        fresh            = sorted_store.pop_front();
        r.taken_value    = fresh.value;
        r.taken_priority = fresh.prio;
      end
    end
    if (sorted_store.size() > 0) begin
      r.head_value    = sorted_store[0].value;
      r.head_priority = sorted_store[0].prio;
    end
    r.entry_count = COUNT_W'(sorted_store.size());
    if (sorted_store.size() > peak_fill) peak_fill = sorted_store.size();
    return r;
  endfunction

  // Count a failure; describe only the first ten.
  function automatic void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, msg);
  endfunction

  function automatic void check_report(spq_out_t got, spq_out_t want);
    if (got.status !== want.status)
      flag($sformatf("status: expected %0d, got %0d", want.status, got.status));
    if (got.taken_value !== want.taken_value)
      flag($sformatf("taken_value: expected %0d, got %0d", want.taken_value, got.taken_value));
    if (got.taken_priority !== want.taken_priority)
      flag($sformatf("taken_priority: expected %0d, got %0d",
                     want.taken_priority, got.taken_priority));
    if (got.head_value !== want.head_value)
      flag($sformatf("head_value: expected %0d, got %0d", want.head_value, got.head_value));
    if (got.head_priority !== want.head_priority)
      flag($sformatf("head_priority: expected %0d, got %0d",
                     want.head_priority, got.head_priority));
    if (got.entry_count !== want.entry_count)
      flag($sformatf("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count));
  endfunction

  // -------------------------------------------------------------------------
  // Monitor: check result beats, mirror accepted command beats, and end the
  // run if nothing moves on either channel for too long.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    spq_out_t owed;
    if (rst_n) begin
      // Check the result first: a command accepted at this edge can only
      // answer on a later one.
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_reports.size() == 0) flag("result beat with nothing pending");
        else check_report(out_data, pending_reports.pop_front());
      end
      if (in_valid && in_ready) begin
        owed = apply_command(in_data);
        pending_reports.push_back(pin_valid ? pin_report : owed);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Sink: hold out_ready low in random bursts.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= 1'b0;
    end else if (sink_rate != 0 && $urandom_range(1, sink_rate) == 1) begin
      sink_hold <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one command beat and hold it until the block takes it.
  task automatic send_beat(spq_in_t beat, bit pinned, spq_out_t report);
    in_valid   <= 1'b1;
    in_data    <= beat;
    pin_valid  <= pinned;
    pin_report <= report;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid for a random burst, with a chance of 1 in rate.
  task automatic source_gap(int rate);
    if (rate != 0 && $urandom_range(1, rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  function automatic spq_in_t random_beat(int enq_pct, prio_style_t style);
    spq_in_t b;
    b.cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
    case ($urandom_range(0, 11))
      0:       b.item_value = 32'sh8000_0000;
      1:       b.item_value = 32'sh7FFF_FFFF;
      2:       b.item_value = -32'sd1;
      3:       b.item_value = 32'sd0;
      default: b.item_value = $urandom;
    endcase
    case (style)
      PRIO_TIES: b.item_priority = PRIO_W'($urandom_range(0, 3));
      PRIO_ENDS: b.item_priority = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      PRIO_BAND: b.item_priority = PRIO_W'($urandom_range(120, 135));
      default:   b.item_priority = PRIO_W'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin : stimulus
    spq_in_t     beat;
    spq_out_t    report;
    phase_kind_t kind;
    prio_style_t style;
    int          enq_pct;
    int          src_rate;
    int          phase_len;
    bit          calm;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Scripted opening, with light idling on both sides.
    foreach (script[i]) begin
      beat.cmd           = script[i].cmd;
      beat.item_value    = script[i].value;
      beat.item_priority = script[i].prio;
      report                = '0;
      report.status         = script[i].status;
      report.head_value     = script[i].head_value;
      report.head_priority  = script[i].head_prio;
      report.entry_count    = COUNT_W'(script[i].count);
      send_beat(beat, script[i].pinned, report);
      source_gap(4);
    end

    // Random phases: fill towards overflow, drain towards underflow, or churn
    // around the current level. Each phase picks its own priority spread and
    // idling on both sides; the tail of the run has no idling at all.
    report = '0;
    while (beats_sent < SCRIPT_LEN + RANDOM_BEATS) begin
      kind      = phase_kind_t'($urandom_range(0, 2));
      style     = prio_style_t'($urandom_range(0, 3));
      phase_len = $urandom_range(30, 140);
      calm      = (beats_sent >= SCRIPT_LEN + RANDOM_BEATS - CALM_TAIL);
      case (kind)
        PH_FILL:  enq_pct = 85;
        PH_DRAIN: enq_pct = 15;
        default:  enq_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0:       src_rate = 0;
        1:       src_rate = 8;
        default: src_rate = 3;
      endcase
      if (calm) src_rate = 0;
      sink_rate <= calm ? 0 : ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(2, 8));
      repeat (phase_len) begin
        send_beat(random_beat(enq_pct, style), 1'b0, report);
        source_gap(src_rate);
      end
    end

    in_valid  <= 1'b0;
    pin_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_reports.size() != 0)
      flag($sformatf("%0d results never arrived", pending_reports.size()));

    $display("Ran %0d command beats (%0d enqueue, %0d dequeue) and checked %0d results.",
             beats_sent, n_enq, n_deq, results_seen);
    $display("Hit %0d overflows and %0d underflows; deepest fill %0d of %0d entries.",
             n_overflow, n_underflow, peak_fill, DEPTH);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
